### rtl/rsoc_pkg.sv
// ----------------------------------------------------------------------------
// rsoc_pkg
// Shared constants, codes and controller/datapath interface types for the
// rectilinear segment obstacle checker.
// ----------------------------------------------------------------------------
package rsoc_pkg;

  localparam int MAX_OBSTACLES_DEF = 64;
  localparam int COORD_BITS_DEF    = 20;
  localparam int SUM_W             = 32;

  // Command codes; code 3 is unused and ignored.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HIT      = 2'd1,
    ST_NOT_RECT = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE,
    S_REPLY
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    load_wr;
    logic    clear;
    logic    scan_issue;
    logic    sum_add;
    logic    status_wr;
    status_t status_code;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       rect;
    logic       empty;
    logic       last_issue;
    logic       hit;
  } dp_stat_t;

endpackage

### rtl/rsoc_ram.sv
// ----------------------------------------------------------------------------
// rsoc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsoc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rsoc_dp.sv
// ----------------------------------------------------------------------------
// rsoc_dp
// Datapath: item capture, obstacle table, scan compare, count and length sum.
// ----------------------------------------------------------------------------
module rsoc_dp
  import rsoc_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF,
  localparam int CNT_W        = $clog2(MAX_OBSTACLES + 1),
  localparam int AW           = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [1:0]            command,
  input  logic [COORD_BITS-1:0] obs_left,
  input  logic [COORD_BITS-1:0] obs_down,
  input  logic [COORD_BITS-1:0] obs_right,
  input  logic [COORD_BITS-1:0] obs_up,
  input  logic [COORD_BITS-1:0] seg_x0,
  input  logic [COORD_BITS-1:0] seg_y0,
  input  logic [COORD_BITS-1:0] seg_x1,
  input  logic [COORD_BITS-1:0] seg_y1,
  output logic [1:0]            status,
  output logic [SUM_W-1:0]      length_total,
  output logic [CNT_W-1:0]      obstacle_count
);

  localparam int C  = COORD_BITS;
  localparam int WW = 4 * COORD_BITS;

  // captured item
  logic [1:0]    cmd_q;
  logic [WW-1:0] obs_word;
  logic          vert;
  logic          rect;
  logic [C-1:0]  pos;
  logic [C-1:0]  lo;
  logic [C-1:0]  hi;
  logic [C-1:0]  len;

  // capture-side decode of the segment
  logic          vert_c;
  logic          rect_c;
  logic [C-1:0]  a_c;
  logic [C-1:0]  b_c;

  // state
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;
  logic             rd_vld;
  logic             hit;
  status_t          status_q;

  // table read side
  logic [WW-1:0] rdata;
  logic [C-1:0]  r_left, r_right, r_down, r_up;
  logic [C-1:0]  e0, e1, s0, s1;
  logic          edge_hit;
  logic [SUM_W:0] sum_ext;

  assign vert_c = (seg_x0 == seg_x1);
  assign rect_c = vert_c || (seg_y0 == seg_y1);
  assign a_c    = vert_c ? seg_y0 : seg_x0;
  assign b_c    = vert_c ? seg_y1 : seg_x1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= command;
      obs_word <= {obs_up, obs_down, obs_right, obs_left};
      vert     <= vert_c;
      rect     <= rect_c;
      pos      <= vert_c ? seg_x0 : seg_y0;
      lo       <= (a_c < b_c) ? a_c : b_c;
      hi       <= (a_c < b_c) ? b_c : a_c;
    end
    len <= hi - lo;
  end

  rsoc_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (count[AW-1:0]),
    .wdata (obs_word),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // stored word is {up, down, right, left}
  assign r_left  = rdata[C-1:0];
  assign r_right = rdata[2*C-1:C];
  assign r_down  = rdata[3*C-1:2*C];
  assign r_up    = rdata[4*C-1:3*C];

  // vertical: spanned edges are down/up, sides are left/right; horizontal swaps
  assign e0 = vert ? r_down  : r_left;
  assign e1 = vert ? r_up    : r_right;
  assign s0 = vert ? r_left  : r_down;
  assign s1 = vert ? r_right : r_up;

  assign edge_hit = (s0 < pos) && (pos < s1) &&
                    (((e0 >= lo) && (e0 < hi)) || ((e1 > lo) && (e1 <= hi)));

  assign idx_inc = idx + 1'b1;
  assign sum_ext = {1'b0, sum} + (SUM_W + 1)'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sum    <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_issue;
      if (cmd.capture) begin
        idx <= '0;
        hit <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          idx <= idx_inc;
        end
        if (rd_vld && edge_hit) begin
          hit <= 1'b1;
        end
      end
      if (cmd.clear) begin
        count <= '0;
        sum   <= '0;
      end else begin
        if (cmd.load_wr) begin
          count <= count + 1'b1;
        end
        if (cmd.sum_add) begin
          sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.status_wr) begin
      status_q <= cmd.status_code;
    end
  end

  assign stat.command    = cmd_q;
  assign stat.full       = (count == CNT_W'(MAX_OBSTACLES));
  assign stat.rect       = rect;
  assign stat.empty      = (count == '0);
  assign stat.last_issue = (idx_inc == count);
  assign stat.hit        = hit;

  assign status         = status_q;
  assign length_total   = sum;
  assign obstacle_count = count;

endmodule

### rtl/rsoc_ctrl.sv
// ----------------------------------------------------------------------------
// rsoc_ctrl
// Controller: sequences load, check, clear and the result strobe.
// ----------------------------------------------------------------------------
module rsoc_ctrl
  import rsoc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = ST_OK;
    busy            = 1'b1;
    done            = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.command)
          CMD_LOAD: begin
            cmd.status_wr   = 1'b1;
            cmd.status_code = stat.full ? ST_FULL : ST_OK;
            cmd.load_wr     = !stat.full;
            state_next      = S_REPLY;
          end
          CMD_CHECK: begin
            if (!stat.rect) begin
              cmd.status_wr   = 1'b1;
              cmd.status_code = ST_NOT_RECT;
              state_next      = S_REPLY;
            end else if (stat.empty) begin
              state_next = S_RESOLVE;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_CLEAR: begin
            cmd.clear     = 1'b1;
            cmd.status_wr = 1'b1;
            state_next    = S_REPLY;
          end
          default: begin
            cmd.status_wr = 1'b1;
            state_next    = S_REPLY;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.status_wr   = 1'b1;
        cmd.status_code = stat.hit ? ST_HIT : ST_OK;
        cmd.sum_add     = !stat.hit;
        state_next      = S_REPLY;
      end
      S_REPLY: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/rectilinear_segment_obstacle_check.sv
// ----------------------------------------------------------------------------
// rectilinear_segment_obstacle_check
// Rectangle obstacle table with rectilinear wire segment blocking check.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result, shown for a single cycle with done high, and the receiver cannot
// hold it off. A load or clear item goes from accept through decode to the
// reply. A check with a non-empty table scans it, reading one table entry
// per cycle from the single read port of the obstacle RAM, then drains the
// last read and resolves; with an empty table it skips the scan, and when
// the segment is neither vertical nor horizontal it replies straight from
// decode. busy stays high through the done cycle. The table RAM is not
// cleared: only entries below the stored count are ever read.
// ----------------------------------------------------------------------------
module rectilinear_segment_obstacle_check
  import rsoc_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF,
  localparam int CNT_W        = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [COORD_BITS-1:0] obs_left,
  input  logic [COORD_BITS-1:0] obs_down,
  input  logic [COORD_BITS-1:0] obs_right,
  input  logic [COORD_BITS-1:0] obs_up,
  input  logic [COORD_BITS-1:0] seg_x0,
  input  logic [COORD_BITS-1:0] seg_y0,
  input  logic [COORD_BITS-1:0] seg_x1,
  input  logic [COORD_BITS-1:0] seg_y1,
  output logic                  done,
  output logic [1:0]            status,
  output logic [SUM_W-1:0]      length_total,
  output logic [CNT_W-1:0]      obstacle_count
);

  // command/status link between controller and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Controller: one item at a time, scan steps through the table
  rsoc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (dp_stat),
    .cmd   (dp_cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: capture, table RAM, edge compare, count and saturating sum
  rsoc_dp #(
    .MAX_OBSTACLES (MAX_OBSTACLES),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .command        (command),
    .obs_left       (obs_left),
    .obs_down       (obs_down),
    .obs_right      (obs_right),
    .obs_up         (obs_up),
    .seg_x0         (seg_x0),
    .seg_y0         (seg_y0),
    .seg_x1         (seg_x1),
    .seg_y1         (seg_y1),
    .status         (status),
    .length_total   (length_total),
    .obstacle_count (obstacle_count)
  );

endmodule

### rtl/rsoc_chk.sv
// ----------------------------------------------------------------------------
// rsoc_chk
// Port-level checks for the obstacle checker, bound to the top level.
// ----------------------------------------------------------------------------
module rsoc_chk
  import rsoc_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF,
  localparam int CNT_W        = $clog2(MAX_OBSTACLES + 1)
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [1:0]       status,
  input logic [SUM_W-1:0] length_total,
  input logic [CNT_W-1:0] obstacle_count
);

  // an accepted item occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accept");

  // result strobe only while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // block frees up right after the result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after done");

  // the count never exceeds the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    obstacle_count <= CNT_W'(MAX_OBSTACLES))
    else $error("obstacle count above table size");

  // rejected items leave the length total alone
  a_reject_sum: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_HIT || status == ST_NOT_RECT || status == ST_FULL))
      |-> $stable(length_total))
    else $error("total changed on a rejected item");

endmodule

bind rectilinear_segment_obstacle_check rsoc_chk #(
  .MAX_OBSTACLES (MAX_OBSTACLES)
) u_rsoc_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .length_total   (length_total),
  .obstacle_count (obstacle_count)
);
